>>> rtl/grid_subset_bounding_window_assert.svh
// Assertion macros for the grid subset bounding window block.
// Included by the top level; has no other dependencies.
`ifndef GRID_SUBSET_BOUNDING_WINDOW_ASSERT_SVH
`define GRID_SUBSET_BOUNDING_WINDOW_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication checked in the same cycle.
`define GSBW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the next cycle.
`define GSBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSBW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define GSBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/gsbw_pkg.sv
// Shared widths, reset values, register indexes and structs for the
// grid subset bounding window block. No dependencies.
package gsbw_pkg;

    // Field widths.
    localparam int LON_W   = 31;
    localparam int LAT_W   = 30;
    localparam int COLS_W  = 13;
    localparam int FIELD_W = 12;

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Default grid dimension limit.
    localparam int DEFAULT_MAX_GRID_DIM = 4096;

    // Register reset values.
    localparam logic signed [LON_W-1:0] LON_MIN_RST  = -31'sd754974720;
    localparam logic signed [LON_W-1:0] LON_MAX_RST  = 31'sd754974720;
    localparam logic signed [LAT_W-1:0] LAT_MIN_RST  = -30'sd377487360;
    localparam logic signed [LAT_W-1:0] LAT_MAX_RST  = 30'sd377487360;
    localparam logic [COLS_W-1:0]       GRID_COLS_RST = 13'd4096;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_LON_MIN      = 3'd0,
        REG_LON_MAX      = 3'd1,
        REG_LAT_MIN      = 3'd2,
        REG_LAT_MAX      = 3'd3,
        REG_GRID_COLUMNS = 3'd4
    } reg_idx_t;

    // One classified point handed to the tracker.
    typedef struct packed {
        logic advance;
        logic in_bounds;
        logic last;
    } step_t;

    // One result item.
    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] first_row;
        logic [FIELD_W-1:0] last_row;
        logic [FIELD_W-1:0] first_column;
        logic [FIELD_W-1:0] last_column;
    } result_t;

endpackage

>>> rtl/gsbw_point_if.sv
// Input channel interface: one grid point per transfer.
// Depends on gsbw_pkg for field widths.
interface gsbw_point_if import gsbw_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [LON_W-1:0]  longitude;
    logic signed [LAT_W-1:0]  latitude;
    logic                     last_point;

    modport source (output valid, output longitude, output latitude, output last_point,
                     input ready);
    modport sink   (input valid, input longitude, input latitude, input last_point,
                     output ready);

endinterface

>>> rtl/gsbw_window_if.sv
// Output channel interface: one bounding window per transfer.
// Depends on gsbw_pkg for field widths.
interface gsbw_window_if import gsbw_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               found;
    logic [FIELD_W-1:0] first_row;
    logic [FIELD_W-1:0] last_row;
    logic [FIELD_W-1:0] first_column;
    logic [FIELD_W-1:0] last_column;

    modport source (output valid, output found, output first_row, output last_row,
                     output first_column, output last_column, input ready);
    modport sink   (input valid, input found, input first_row, input last_row,
                     input first_column, input last_column, output ready);

endinterface

>>> rtl/gsbw_tracker.sv
// Row/column position counter and running min/max window of inside points.
// Depends on gsbw_pkg for the step and result structs.
module gsbw_tracker import gsbw_pkg::*; #(
    parameter int MAX_GRID_DIM = DEFAULT_MAX_GRID_DIM
) (
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step,
    input  logic [COLS_W-1:0] grid_columns,
    output result_t           window_next
);

    localparam int POS_W = $clog2(MAX_GRID_DIM);
    localparam int CMP_W = (POS_W + 1 > COLS_W) ? POS_W + 1 : COLS_W;

    logic [POS_W-1:0] row_pos_reg, row_pos_next;
    logic [POS_W-1:0] col_pos_reg, col_pos_next;
    logic             any_reg, any_next;
    logic [POS_W-1:0] min_row_reg, min_row_next;
    logic [POS_W-1:0] max_row_reg, max_row_next;
    logic [POS_W-1:0] min_col_reg, min_col_next;
    logic [POS_W-1:0] max_col_reg, max_col_next;

    logic [POS_W-1:0] min_row_upd, max_row_upd, min_col_upd, max_col_upd;
    logic             any_upd;
    logic [CMP_W-1:0] cols_ext, cols_eff, col_inc;
    logic             row_wrap;

    // Fold the current point into the window.
    always_comb
    begin
        any_upd     = any_reg | step.in_bounds;
        min_row_upd = min_row_reg;
        max_row_upd = max_row_reg;
        min_col_upd = min_col_reg;
        max_col_upd = max_col_reg;
        if (step.in_bounds && !any_reg)
        begin
            min_row_upd = row_pos_reg;
            max_row_upd = row_pos_reg;
            min_col_upd = col_pos_reg;
            max_col_upd = col_pos_reg;
        end
        else if (step.in_bounds)
        begin
            if (row_pos_reg < min_row_reg) min_row_upd = row_pos_reg;
            if (row_pos_reg > max_row_reg) max_row_upd = row_pos_reg;
            if (col_pos_reg < min_col_reg) min_col_upd = col_pos_reg;
            if (col_pos_reg > max_col_reg) max_col_upd = col_pos_reg;
        end
    end

    // The result as it stands after this point; zero window when nothing was inside.
    always_comb
    begin
        window_next.found        = any_upd;
        window_next.first_row    = any_upd ? FIELD_W'(min_row_upd) : '0;
        window_next.last_row     = any_upd ? FIELD_W'(max_row_upd) : '0;
        window_next.first_column = any_upd ? FIELD_W'(min_col_upd) : '0;
        window_next.last_column  = any_upd ? FIELD_W'(max_col_upd) : '0;
    end

    // Effective row length: zero acts as one, and it is capped at the grid limit.
    always_comb
    begin
        cols_ext = CMP_W'(grid_columns);
        priority if (cols_ext == '0)
            cols_eff = CMP_W'(1);
        else if (cols_ext > CMP_W'(MAX_GRID_DIM))
            cols_eff = CMP_W'(MAX_GRID_DIM);
        else
            cols_eff = cols_ext;
        col_inc  = CMP_W'(col_pos_reg) + CMP_W'(1);
        row_wrap = (col_inc >= cols_eff);
    end

    // Next state: clear after the last point, else advance the position.
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        any_next     = any_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        if (step.advance && step.last)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
            any_next     = 1'b0;
            min_row_next = '0;
            max_row_next = '0;
            min_col_next = '0;
            max_col_next = '0;
        end
        else if (step.advance)
        begin
            any_next     = any_upd;
            min_row_next = min_row_upd;
            max_row_next = max_row_upd;
            min_col_next = min_col_upd;
            max_col_next = max_col_upd;
            if (row_wrap)
            begin
                col_pos_next = '0;
                // The row counter holds at the top index.
                if (row_pos_reg != POS_W'(MAX_GRID_DIM - 1))
                    row_pos_next = row_pos_reg + POS_W'(1);
            end
            else
            begin
                col_pos_next = col_inc[POS_W-1:0];
            end
        end
    end

    // Tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            any_reg     <= 1'b0;
            min_row_reg <= '0;
            max_row_reg <= '0;
            min_col_reg <= '0;
            max_col_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            any_reg     <= any_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
        end
    end

endmodule

>>> rtl/grid_subset_bounding_window.sv
// Top level of the grid subset bounding window block: input register, bounds
// compare, tracker and result register. Depends on gsbw_pkg, the two channel
// interfaces, gsbw_tracker and grid_subset_bounding_window_assert.svh.
//
//   channel  | direction | transfer carries
//   ---------+-----------+------------------------------------------------
//   point    | in        | longitude, latitude, last_point
//   window   | out       | found, first_row, last_row, first_column, last_column
//   apb      | in        | register writes and reads, pready always high
//
// One point is taken every cycle but for the stall below; the input register,
// compare/min-max logic and result register lead from point to window. A window
// is given only for a last point and sits in the result register until taken;
// while it waits, non-last points flow and only a further last point stalls the
// input. Reset clears the valid and tracker state and loads the config registers.
`include "grid_subset_bounding_window_assert.svh"
module grid_subset_bounding_window import gsbw_pkg::*; #(
    parameter int MAX_GRID_DIM = DEFAULT_MAX_GRID_DIM
) (
    input  logic               clk,
    input  logic               rst_n,
    gsbw_point_if.sink         point,
    gsbw_window_if.source      window,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers.
    logic signed [LON_W-1:0] lon_min_reg, lon_max_reg;
    logic signed [LAT_W-1:0] lat_min_reg, lat_max_reg;
    logic [COLS_W-1:0]       grid_cols_reg;
    logic                    cfg_write;
    reg_idx_t                cfg_idx;

    // Input register stage.
    logic                    s1_valid_reg;
    logic signed [LON_W-1:0] s1_lon_reg;
    logic signed [LAT_W-1:0] s1_lat_reg;
    logic                    s1_last_reg;

    // Result register stage.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic    out_free;
    logic    s1_adv;
    logic    in_bounds;
    step_t   step;
    result_t window_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_min_reg   <= LON_MIN_RST;
            lon_max_reg   <= LON_MAX_RST;
            lat_min_reg   <= LAT_MIN_RST;
            lat_max_reg   <= LAT_MAX_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LON_MIN:      lon_min_reg   <= pwdata[LON_W-1:0];
                REG_LON_MAX:      lon_max_reg   <= pwdata[LON_W-1:0];
                REG_LAT_MIN:      lat_min_reg   <= pwdata[LAT_W-1:0];
                REG_LAT_MAX:      lat_max_reg   <= pwdata[LAT_W-1:0];
                REG_GRID_COLUMNS: grid_cols_reg <= pwdata[COLS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register reads, bounds sign-extended to the bus width.
    always_comb
    begin
        unique case (cfg_idx)
            REG_LON_MIN:      prdata = {{(PDATA_W-LON_W){lon_min_reg[LON_W-1]}}, lon_min_reg};
            REG_LON_MAX:      prdata = {{(PDATA_W-LON_W){lon_max_reg[LON_W-1]}}, lon_max_reg};
            REG_LAT_MIN:      prdata = {{(PDATA_W-LAT_W){lat_min_reg[LAT_W-1]}}, lat_min_reg};
            REG_LAT_MAX:      prdata = {{(PDATA_W-LAT_W){lat_max_reg[LAT_W-1]}}, lat_max_reg};
            REG_GRID_COLUMNS: prdata = PDATA_W'(grid_cols_reg);
            default:          prdata = '0;
        endcase
    end

    // Flow control: only a last point needs room in the result register.
    assign out_free    = !out_valid_reg || window.ready;
    assign s1_adv      = s1_valid_reg && (!s1_last_reg || out_free);
    assign point.ready = !s1_valid_reg || !s1_last_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (point.ready)
            s1_valid_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (point.valid && point.ready)
        begin
            s1_lon_reg  <= point.longitude;
            s1_lat_reg  <= point.latitude;
            s1_last_reg <= point.last_point;
        end
    end

    // Inclusive bounds test; an empty range lets nothing through.
    assign in_bounds = (s1_lon_reg >= lon_min_reg) && (s1_lon_reg <= lon_max_reg) &&
                       (s1_lat_reg >= lat_min_reg) && (s1_lat_reg <= lat_max_reg);

    always_comb
    begin
        step.advance   = s1_adv;
        step.in_bounds = in_bounds;
        step.last      = s1_last_reg;
    end

    gsbw_tracker #(
        .MAX_GRID_DIM (MAX_GRID_DIM)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .grid_columns (grid_cols_reg),
        .window_next  (window_next)
    );

    // Result register.
    always_comb
    begin
        priority if (s1_adv && s1_last_reg)
            out_valid_next = 1'b1;
        else if (window.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
            out_data_reg <= window_next;
    end

    assign window.valid        = out_valid_reg;
    assign window.found        = out_data_reg.found;
    assign window.first_row    = out_data_reg.first_row;
    assign window.last_row     = out_data_reg.last_row;
    assign window.first_column = out_data_reg.first_column;
    assign window.last_column  = out_data_reg.last_column;

    // A window with nothing found reports all-zero bounds.
    `GSBW_ASSERT_SAME(a_empty_window_zero, clk, rst_n, out_valid_reg && !out_data_reg.found, out_data_reg.first_row == '0 && out_data_reg.last_row == '0 && out_data_reg.first_column == '0 && out_data_reg.last_column == '0, "empty grid gave a nonzero window")
    // A found window is ordered in both directions.
    `GSBW_ASSERT_SAME(a_window_ordered, clk, rst_n, out_valid_reg && out_data_reg.found, out_data_reg.first_row <= out_data_reg.last_row && out_data_reg.first_column <= out_data_reg.last_column, "window bounds out of order")
    // A last point that leaves the input register always lands in the result register.
    `GSBW_ASSERT_NEXT(a_last_loads_result, clk, rst_n, s1_adv && s1_last_reg, out_valid_reg, "last point produced no result")

endmodule

>>> tb/sv/grid_subset_bounding_window_tb.sv
// Self-checking testbench for grid_subset_bounding_window: drives grid points, predicts
// the bounding window of inside points per grid and checks every window transfer.
// Depends on gsbw_pkg, gsbw_point_if, gsbw_window_if and the block's RTL.
module grid_subset_bounding_window_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gsbw_pkg::*;

    localparam int     GRID_LIMIT    = DEFAULT_MAX_GRID_DIM;
    localparam int     MAX_REPORTS   = 10;
    localparam int     SETTLE_CYCLES = 4;
    localparam longint LON_SPAN      = 754974720;
    localparam longint LAT_SPAN      = 377487360;
    localparam longint LON_FULL_MIN  = -(longint'(1) << (LON_W - 1));
    localparam longint LON_FULL_MAX  = (longint'(1) << (LON_W - 1)) - 1;
    localparam longint LAT_FULL_MIN  = -(longint'(1) << (LAT_W - 1));
    localparam longint LAT_FULL_MAX  = (longint'(1) << (LAT_W - 1)) - 1;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    gsbw_point_if  point_ch ();
    gsbw_window_if window_ch ();

    grid_subset_bounding_window #(
        .MAX_GRID_DIM(GRID_LIMIT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point_ch),
        .window  (window_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Idle rates of the point sender and the window receiver, in percent.
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 47;

    // Shadow copy of the configuration registers.
    logic signed [LON_W-1:0] cfg_lon_min  = LON_MIN_RST;
    logic signed [LON_W-1:0] cfg_lon_max  = LON_MAX_RST;
    logic signed [LAT_W-1:0] cfg_lat_min  = LAT_MIN_RST;
    logic signed [LAT_W-1:0] cfg_lat_max  = LAT_MAX_RST;
    logic [COLS_W-1:0]       cfg_columns  = GRID_COLS_RST;

    // Grid position and window seen so far in the current grid.
    logic [FIELD_W-1:0] row_pos  = '0;
    logic [FIELD_W-1:0] col_pos  = '0;
    logic               any_in   = 1'b0;
    logic [FIELD_W-1:0] min_row  = '0;
    logic [FIELD_W-1:0] max_row  = '0;
    logic [FIELD_W-1:0] min_col  = '0;
    logic [FIELD_W-1:0] max_col  = '0;

    result_t expected_windows[$];
    int      mismatch_count = 0;
    int      points_sent    = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit for the run.
    initial
    begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Window receiver: ready is pulled low at random per the current idle rate.
    always @(posedge clk)
    begin
        window_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Window checker: every transfer is compared with the oldest predicted window.
    always @(posedge clk)
    begin : window_check
        result_t got;
        result_t want;
        if (rst_n && window_ch.valid && window_ch.ready)
        begin
            got.found        = window_ch.found;
            got.first_row    = window_ch.first_row;
            got.last_row     = window_ch.last_row;
            got.first_column = window_ch.first_column;
            got.last_column  = window_ch.last_column;
            if (expected_windows.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: window transfer with none expected: found=%0b rows %0d..%0d cols %0d..%0d",
                             $realtime, got.found, got.first_row, got.last_row,
                             got.first_column, got.last_column);
            end
            else
            begin
                want = expected_windows.pop_front();
                if (got.found !== want.found || got.first_row !== want.first_row
                    || got.last_row !== want.last_row
                    || got.first_column !== want.first_column
                    || got.last_column !== want.last_column)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: window mismatch", $realtime);
                        $display("  found        exp %0d act %0d", want.found, got.found);
                        $display("  first_row    exp %0d act %0d", want.first_row, got.first_row);
                        $display("  last_row     exp %0d act %0d", want.last_row, got.last_row);
                        $display("  first_column exp %0d act %0d",
                                 want.first_column, got.first_column);
                        $display("  last_column  exp %0d act %0d",
                                 want.last_column, got.last_column);
                    end
                end
            end
        end
    end

    // Classify one accepted point, update the window and, on a last point,
    // queue the window and start a fresh grid.
    function automatic void track_point(input logic signed [LON_W-1:0] lon,
                                        input logic signed [LAT_W-1:0] lat,
                                        input logic last);
        int unsigned cols;
        logic        in_bounds;
        result_t     window;
        in_bounds = lon >= cfg_lon_min && lon <= cfg_lon_max
                    && lat >= cfg_lat_min && lat <= cfg_lat_max;
        cols = cfg_columns;
        if (cols == 0)
            cols = 1;
        if (cols > GRID_LIMIT)
            cols = GRID_LIMIT;

        if (in_bounds)
        begin
            if (!any_in)
            begin
                min_row = row_pos;
                max_row = row_pos;
                min_col = col_pos;
                max_col = col_pos;
                any_in  = 1'b1;
            end
            else
            begin
                if (row_pos < min_row) min_row = row_pos;
                if (row_pos > max_row) max_row = row_pos;
                if (col_pos < min_col) min_col = col_pos;
                if (col_pos > max_col) max_col = col_pos;
            end
        end

        if (last)
        begin
            window.found        = any_in;
            window.first_row    = any_in ? min_row : '0;
            window.last_row     = any_in ? max_row : '0;
            window.first_column = any_in ? min_col : '0;
            window.last_column  = any_in ? max_col : '0;
            expected_windows.push_back(window);
            row_pos = '0;
            col_pos = '0;
            any_in  = 1'b0;
            min_row = '0;
            max_row = '0;
            min_col = '0;
            max_col = '0;
        end
        else if (int'(col_pos) + 1 >= cols)
        begin
            // End of a row; the row index sticks at the top of the grid.
            col_pos = '0;
            if (int'(row_pos) + 1 < GRID_LIMIT)
                row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // Send one grid point, idling at random before it, and predict on acceptance.
    // Coordinates are taken as wide values and cut to the field widths.
    task automatic send_point(input longint lon, input longint lat, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid      <= 1'b1;
        point_ch.longitude  <= lon[LON_W-1:0];
        point_ch.latitude   <= lat[LAT_W-1:0];
        point_ch.last_point <= last;
        do
            @(posedge clk);
        while (!point_ch.ready);
        track_point(lon[LON_W-1:0], lat[LAT_W-1:0], last);
        points_sent++;
    endtask

    // Stop sending, wait for every predicted window and let the pipeline empty.
    task automatic drain_and_settle();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: setup phase, access phase, then an idle phase.
    task automatic write_register(input reg_idx_t idx, input longint value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value[PDATA_W-1:0];
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LON_MIN:      cfg_lon_min = value[LON_W-1:0];
            REG_LON_MAX:      cfg_lon_max = value[LON_W-1:0];
            REG_LAT_MIN:      cfg_lat_min = value[LAT_W-1:0];
            REG_LAT_MAX:      cfg_lat_max = value[LAT_W-1:0];
            REG_GRID_COLUMNS: cfg_columns = value[COLS_W-1:0];
            default:          ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all registers once the block has gone idle.
    task automatic write_bounds(input longint lon_lo, input longint lon_hi,
                                input longint lat_lo, input longint lat_hi,
                                input longint columns);
        drain_and_settle();
        write_register(REG_LON_MIN, lon_lo);
        write_register(REG_LON_MAX, lon_hi);
        write_register(REG_LAT_MIN, lat_lo);
        write_register(REG_LAT_MAX, lat_hi);
        write_register(REG_GRID_COLUMNS, columns);
    endtask

    // A coordinate mostly inside [lo, hi], often on or just past an edge,
    // sometimes anywhere in the legal span or any bit pattern at all.
    function automatic logic [31:0] pick_coord(input longint lo, input longint hi,
                                               input longint span);
        int unsigned r;
        longint      v;
        r = $urandom_range(99);
        if (r < 40 && lo <= hi)
            v = lo + longint'($urandom_range(hi - lo));
        else if (r < 55)
            v = $urandom_range(1) ? lo : hi;
        else if (r < 65)
            v = $urandom_range(1) ? lo - 1 : hi + 1;
        else if (r < 85)
            v = -span + longint'($urandom_range(2 * span));
        else
            v = longint'($urandom);
        return v[31:0];
    endfunction

    // Random bound pair: full span, empty, single value, narrow or general.
    task automatic random_bounds(input longint span, output longint lo, output longint hi);
        int unsigned r;
        longint      a;
        longint      b;
        r = $urandom_range(99);
        a = -span + longint'($urandom_range(2 * span));
        b = -span + longint'($urandom_range(2 * span));
        if (a == b)
            b = a - 1;
        if (r < 10)
        begin
            lo = -span;
            hi = span;
        end
        else if (r < 20)
        begin
            // Minimum above maximum: nothing can be inside.
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end
        else if (r < 30)
        begin
            lo = a;
            hi = a;
        end
        else if (r < 45)
        begin
            lo = a;
            hi = a + longint'($urandom_range(1000));
        end
        else
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
    endtask

    // One complete grid of random points ending on a last point.
    task automatic send_random_grid();
        int count;
        count = ($urandom_range(99) < 5) ? $urandom_range(300, 41) : $urandom_range(40, 1);
        for (int i = 0; i < count; i++)
            send_point(pick_coord(cfg_lon_min, cfg_lon_max, LON_SPAN),
                       pick_coord(cfg_lat_min, cfg_lat_max, LAT_SPAN),
                       i == count - 1);
    endtask

    // Long grid with the bounds at the origin: inside points only at two
    // chosen positions and at the last point, all others outside.
    task automatic send_sparse_grid(input int count, input int hit_a, input int hit_b);
        for (int i = 0; i < count; i++)
        begin
            if (i == hit_a || i == hit_b || i == count - 1)
                send_point('0, '0, i == count - 1);
            else
                send_point(1 + $urandom_range(1000), $urandom, 1'b0);
        end
    endtask

    // Reset register values: corners of the legal span, single-point grids inside
    // and outside, and a grid with two points just past the edges.
    task automatic test_reset_defaults();
        send_point(LON_SPAN, LAT_SPAN, 1'b1);
        send_point(-LON_SPAN, -LAT_SPAN, 1'b0);
        send_point(-LON_SPAN - 1, 0, 1'b0);
        send_point(0, LAT_SPAN + 1, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(LON_FULL_MAX, LAT_FULL_MIN, 1'b1);
    endtask

    // Degenerate and empty bounds, and the full two's complement range.
    task automatic test_directed_bounds();
        write_bounds(0, 0, 0, 0, 2);
        send_point(0, 0, 1'b0);
        send_point(1, 0, 1'b0);
        send_point(0, -1, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b1);

        // Empty longitude range.
        write_bounds(1, 0, -LAT_SPAN, LAT_SPAN, 3);
        send_point(0, 0, 1'b0);
        send_point(1, 0, 1'b1);

        // Empty latitude range.
        write_bounds(-LON_SPAN, LON_SPAN, 5, 4, 3);
        send_point(0, 4, 1'b0);
        send_point(0, 5, 1'b1);

        write_bounds(LON_FULL_MIN, LON_FULL_MAX, LAT_FULL_MIN, LAT_FULL_MAX, 1);
        send_point(LON_FULL_MIN, LAT_FULL_MIN, 1'b0);
        send_point(LON_FULL_MAX, LAT_FULL_MAX, 1'b0);
        send_point(0, 0, 1'b1);
    endtask

    // Random grids over several register settings and all idle patterns.
    task automatic test_random_grids();
        longint lon_lo;
        longint lon_hi;
        longint lat_lo;
        longint lat_hi;
        longint columns;
        int     r;
        int     target;
        for (int phase = 0; phase < 6; phase++)
        begin
            random_bounds(LON_SPAN, lon_lo, lon_hi);
            random_bounds(LAT_SPAN, lat_lo, lat_hi);
            r = $urandom_range(99);
            if (r < 10)
                columns = 0;
            else if (r < 18)
                columns = GRID_LIMIT;
            else if (r < 24)
                columns = $urandom_range(8191, GRID_LIMIT + 1);
            else if (r < 30)
                columns = $urandom_range(200, 13);
            else
                columns = $urandom_range(12, 1);
            write_bounds(lon_lo, lon_hi, lat_lo, lat_hi, columns);

            // Idle patterns change in pairs of phases.
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            target = points_sent + 160;
            while (points_sent < target)
                send_random_grid();
        end
    endtask

    // Zero columns act as one column, so each point starts a new row.
    task automatic test_zero_columns_rows();
        write_bounds(0, 0, 0, 0, 0);
        send_sparse_grid(150, 3, 100);
    endtask

    // Columns above the grid limit keep every point of a short grid in row zero.
    task automatic test_wide_rows();
        write_bounds(0, 0, 0, 0, 8191);
        send_sparse_grid(120, 5, 110);
    endtask

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        point_ch.valid      = 1'b0;
        point_ch.longitude  = '0;
        point_ch.latitude   = '0;
        point_ch.last_point = 1'b0;
        window_ch.ready     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_bounds();
        test_random_grids();
        test_zero_columns_rows();
        test_wide_rows();

        drain_and_settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_windows.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> grid_subset_bounding_window.f
+incdir+rtl
rtl/gsbw_pkg.sv
rtl/gsbw_point_if.sv
rtl/gsbw_window_if.sv
rtl/gsbw_tracker.sv
rtl/grid_subset_bounding_window.sv
tb/sv/grid_subset_bounding_window_tb.sv
